// ===== rtl/tclf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tclf_pkg;

  localparam int CHANNELS   = 3;
  localparam int ENCODERS   = 2;
  localparam int DUTY_BITS  = 8;
  localparam int CFG_IDX_BITS = 3;

  typedef logic [DUTY_BITS-1:0] level_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PRESET_ONE   = 3'd0,
    CFG_PRESET_TWO   = 3'd1,
    CFG_PRESET_THREE = 3'd2,
    CFG_MAX_LEVEL    = 3'd3,
    CFG_MIN_LEVEL    = 3'd4
  } cfg_reg_t;

  localparam level_t PRESET_ONE_RST   = 8'd100;
  localparam level_t PRESET_TWO_RST   = 8'd50;
  localparam level_t PRESET_THREE_RST = 8'd100;
  localparam level_t MAX_LEVEL_RST    = 8'd255;
  localparam level_t MIN_LEVEL_RST    = 8'd1;

  localparam level_t LEVEL_RST [CHANNELS] = '{8'd100, 8'd50, 8'd150};

endpackage

`default_nettype wire

// ===== rtl/three_channel_led_fader_core.sv =====
// three-channel led fader core
// input channel: one word per tick with the three channel toggle edges, the
// master edge and the two signed encoder counts; accepted when in_valid is
// high and in_stall is low
// output channel: one word per accepted tick carrying the three held pwm
// duties; taken when out_valid is high and out_stall is low
// latency: the duties for a tick show on the cycle after it is accepted
// throughput: one tick per cycle unless a stalled result holds the input,
// set by the single state update stage between the handshake and duty registers
// stall: while a result waits under out_stall, in_stall is raised and the
// duties hold; with the output register empty or being taken, a new tick
// is accepted in the same cycle
// reset (rst, synchronous): all channels lit and steady at levels 100, 50,
// 150, no fades running, duties and encoder history zero, registers at
// their defaults, no result pending
// configuration: cfg_we writes cfg_data into register cfg_index; write it
// only while no tick is in flight
`timescale 1ns / 1ps
`default_nettype none

module three_channel_led_fader_core
  import tclf_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [DUTY_BITS-1:0]         cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         toggle_one,
  input  logic                         toggle_two,
  input  logic                         toggle_three,
  input  logic                         master_press,
  input  logic signed [COUNT_BITS-1:0] count_one,
  input  logic signed [COUNT_BITS-1:0] count_two,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [DUTY_BITS-1:0]         duty_one,
  output logic [DUTY_BITS-1:0]         duty_two,
  output logic [DUTY_BITS-1:0]         duty_three
);

  level_t preset_one, preset_two, preset_three, max_level, min_level;

  level_t                      level      [CHANNELS];
  level_t                      fade_value [CHANNELS];
  level_t                      held_duty  [CHANNELS];
  logic [CHANNELS-1:0]         lit, rising, falling;
  logic signed [COUNT_BITS-1:0] last_count [ENCODERS];

  level_t                      level_next      [CHANNELS];
  level_t                      fade_value_next [CHANNELS];
  level_t                      held_duty_next  [CHANNELS];
  logic [CHANNELS-1:0]         lit_next, rising_next, falling_next;
  logic [CHANNELS-1:0]         steady;
  logic signed [COUNT_BITS-1:0] last_count_next [ENCODERS];
  logic signed [COUNT_BITS-1:0] count_in [ENCODERS];
  logic [CHANNELS-1:0]         toggles;
  logic                        in_accept;

  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign toggles   = {toggle_three, toggle_two, toggle_one};
  assign count_in[0] = count_one;
  assign count_in[1] = count_two;

  assign duty_one   = held_duty[0];
  assign duty_two   = held_duty[1];
  assign duty_three = held_duty[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      preset_one   <= PRESET_ONE_RST;
      preset_two   <= PRESET_TWO_RST;
      preset_three <= PRESET_THREE_RST;
      max_level    <= MAX_LEVEL_RST;
      min_level    <= MIN_LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PRESET_ONE:   preset_one   <= cfg_data;
        CFG_PRESET_TWO:   preset_two   <= cfg_data;
        CFG_PRESET_THREE: preset_three <= cfg_data;
        CFG_MAX_LEVEL:    max_level    <= cfg_data;
        CFG_MIN_LEVEL:    min_level    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    lit_next     = lit;
    rising_next  = rising;
    falling_next = falling;
    steady       = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      level_next[i]      = level[i];
      fade_value_next[i] = fade_value[i];
      held_duty_next[i]  = held_duty[i];
    end
    for (int j = 0; j < ENCODERS; j++) begin
      last_count_next[j] = last_count[j];
    end

    // channel toggles
    for (int i = 0; i < CHANNELS; i++) begin
      if (toggles[i]) begin
        if (lit[i]) begin
          lit_next[i]        = 1'b0;
          fade_value_next[i] = level[i];
          rising_next[i]     = 1'b0;
          falling_next[i]    = 1'b1;
        end else begin
          lit_next[i]     = 1'b1;
          rising_next[i]  = 1'b1;
          falling_next[i] = 1'b0;
        end
      end
    end

    // master all-off / all-on
    if (master_press) begin
      if (|lit_next) begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (lit_next[i]) begin
            lit_next[i]        = 1'b0;
            fade_value_next[i] = level_next[i];
            rising_next[i]     = 1'b0;
            falling_next[i]    = 1'b1;
          end
        end
      end else begin
        level_next[0] = preset_one;
        level_next[1] = preset_two;
        level_next[2] = preset_three;
        lit_next      = '1;
        rising_next   = '1;
        falling_next  = '0;
      end
    end

    // per-channel fade or steady output
    for (int i = 0; i < CHANNELS; i++) begin
      if (lit_next[i]) begin
        if (rising_next[i]) begin
          if (fade_value_next[i] < level_next[i]) begin
            fade_value_next[i] = fade_value_next[i] + level_t'(1);
            held_duty_next[i]  = fade_value_next[i];
          end else begin
            rising_next[i] = 1'b0;
          end
        end else begin
          held_duty_next[i] = level_next[i];
          steady[i]         = 1'b1;
        end
      end else begin
        if (falling_next[i]) begin
          if (fade_value_next[i] != '0) begin
            fade_value_next[i] = fade_value_next[i] - level_t'(1);
            held_duty_next[i]  = fade_value_next[i];
          end else begin
            falling_next[i] = 1'b0;
          end
        end else begin
          held_duty_next[i] = '0;
        end
      end
    end

    // encoder step after the duty took the old level
    for (int j = 0; j < ENCODERS; j++) begin
      if (steady[j]) begin
        if (count_in[j] > last_count[j] && level_next[j] < max_level) begin
          level_next[j] = level_next[j] + level_t'(1);
        end else if (count_in[j] < last_count[j] && level_next[j] > min_level) begin
          level_next[j] = level_next[j] - level_t'(1);
        end
        last_count_next[j] = count_in[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lit       <= '1;
      rising    <= '0;
      falling   <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        level[i]      <= LEVEL_RST[i];
        fade_value[i] <= '0;
        held_duty[i]  <= '0;
      end
      for (int j = 0; j < ENCODERS; j++) begin
        last_count[j] <= '0;
      end
    end else begin
      if (in_accept) begin
        lit     <= lit_next;
        rising  <= rising_next;
        falling <= falling_next;
        for (int i = 0; i < CHANNELS; i++) begin
          level[i]      <= level_next[i];
          fade_value[i] <= fade_value_next[i];
          held_duty[i]  <= held_duty_next[i];
        end
        for (int j = 0; j < ENCODERS; j++) begin
          last_count[j] <= last_count_next[j];
        end
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tclf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tclf_checker
  import tclf_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [DUTY_BITS-1:0] duty_one,
  input logic [DUTY_BITS-1:0] duty_two,
  input logic [DUTY_BITS-1:0] duty_three
);

  // no word pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word pending after reset");

  // input stalls only behind a stalled output word
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output stall");

  // every accepted tick produces a word next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted tick gave no output word");

  // duties only move when a tick is accepted
  a_duty_hold: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && !in_stall) |=>
      $stable(duty_one) && $stable(duty_two) && $stable(duty_three))
    else $error("duties changed without an accepted tick");

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled output word dropped");

endmodule

bind three_channel_led_fader_core tclf_checker u_tclf_checker (.*);

`default_nettype wire

// ===== bench/three_channel_led_fader_core_checker.sv =====
`timescale 1ns / 1ps

module three_channel_led_fader_core_checker
  import tclf_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [DUTY_BITS-1:0]         cfg_data,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         toggle_one,
  input  logic                         toggle_two,
  input  logic                         toggle_three,
  input  logic                         master_press,
  input  logic signed [COUNT_BITS-1:0] count_one,
  input  logic signed [COUNT_BITS-1:0] count_two,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [DUTY_BITS-1:0]         duty_one,
  input  logic [DUTY_BITS-1:0]         duty_two,
  input  logic [DUTY_BITS-1:0]         duty_three,
  output int                           mismatches,
  output int                           outstanding
);

  typedef struct packed {
    level_t one;
    level_t two;
    level_t three;
  } duty_word_t;

  level_t preset [CHANNELS];
  level_t ceiling;
  level_t floor_level;
  level_t level [CHANNELS];
  level_t fade [CHANNELS];
  level_t held [CHANNELS];
  logic   lit [CHANNELS];
  logic   rising [CHANNELS];
  logic   falling [CHANNELS];
  logic signed [COUNT_BITS-1:0] last_pos [ENCODERS];

  duty_word_t duty_fifo [$];
  duty_word_t want_word;
  duty_word_t next_word;

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_duty(input string name, input level_t got, input level_t want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  task automatic switch_off(input int ch);
    lit[ch] = 1'b0;
    fade[ch] = level[ch];
    rising[ch] = 1'b0;
    falling[ch] = 1'b1;
  endtask

  task automatic fade_tick(
    input  logic [CHANNELS-1:0]          press,
    input  logic                         master,
    input  logic signed [COUNT_BITS-1:0] pos_one,
    input  logic signed [COUNT_BITS-1:0] pos_two,
    output duty_word_t                   word
  );
    logic signed [COUNT_BITS-1:0] pos [ENCODERS];
    pos[0] = pos_one;
    pos[1] = pos_two;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      if (press[ch]) begin
        if (lit[ch]) begin
          switch_off(ch);
        end else begin
          lit[ch] = 1'b1;
          rising[ch] = 1'b1;
          falling[ch] = 1'b0;
        end
      end
    end
    if (master) begin
      if (lit[0] || lit[1] || lit[2]) begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
          if (lit[ch]) switch_off(ch);
        end
      end else begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
          level[ch] = preset[ch];
          lit[ch] = 1'b1;
          rising[ch] = 1'b1;
          falling[ch] = 1'b0;
        end
      end
    end
    for (int ch = 0; ch < CHANNELS; ch++) begin
      if (lit[ch]) begin
        if (rising[ch]) begin
          if (fade[ch] < level[ch]) begin
            fade[ch] = fade[ch] + 1'b1;
            held[ch] = fade[ch];
          end else begin
            rising[ch] = 1'b0;
          end
        end else begin
          held[ch] = level[ch];
          if (ch < ENCODERS) begin
            // one step per tick toward the encoder movement
            if (pos[ch] > last_pos[ch] && level[ch] < ceiling) begin
              level[ch] = level[ch] + 1'b1;
            end else if (pos[ch] < last_pos[ch] && level[ch] > floor_level) begin
              level[ch] = level[ch] - 1'b1;
            end
            last_pos[ch] = pos[ch];
          end
        end
      end else begin
        if (falling[ch]) begin
          if (fade[ch] > 0) begin
            fade[ch] = fade[ch] - 1'b1;
            held[ch] = fade[ch];
          end else begin
            falling[ch] = 1'b0;
          end
        end else begin
          held[ch] = '0;
        end
      end
    end
    word = {held[0], held[1], held[2]};
  endtask

  always @(posedge clk) begin
    if (rst) begin
      preset[0] = PRESET_ONE_RST;
      preset[1] = PRESET_TWO_RST;
      preset[2] = PRESET_THREE_RST;
      ceiling = MAX_LEVEL_RST;
      floor_level = MIN_LEVEL_RST;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        level[ch] = LEVEL_RST[ch];
        fade[ch] = '0;
        held[ch] = '0;
        lit[ch] = 1'b1;
        rising[ch] = 1'b0;
        falling[ch] = 1'b0;
      end
      for (int e = 0; e < ENCODERS; e++) last_pos[e] = '0;
      duty_fifo.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (duty_fifo.size() == 0) begin
          report_mismatch($sformatf("duty word %0d %0d %0d with nothing expected",
                                    duty_one, duty_two, duty_three));
        end else begin
          want_word = duty_fifo.pop_front();
          check_duty("duty_one", duty_one, want_word.one);
          check_duty("duty_two", duty_two, want_word.two);
          check_duty("duty_three", duty_three, want_word.three);
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_PRESET_ONE:   preset[0] = cfg_data;
          CFG_PRESET_TWO:   preset[1] = cfg_data;
          CFG_PRESET_THREE: preset[2] = cfg_data;
          CFG_MAX_LEVEL:    ceiling = cfg_data;
          CFG_MIN_LEVEL:    floor_level = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        fade_tick({toggle_three, toggle_two, toggle_one}, master_press, count_one, count_two,
                  next_word);
        duty_fifo.push_back(next_word);
      end
    end
    outstanding <= duty_fifo.size();
  end

endmodule

// ===== bench/three_channel_led_fader_core_tb.sv =====
`timescale 1ns / 1ps

module three_channel_led_fader_core_tb;
  import tclf_pkg::*;

  localparam int COUNT_BITS = 16;
  localparam int PHASE_TICKS = 170;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]      cfg_index = CFG_PRESET_ONE;
  logic [DUTY_BITS-1:0]         cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         toggle_one = 1'b0;
  logic                         toggle_two = 1'b0;
  logic                         toggle_three = 1'b0;
  logic                         master_press = 1'b0;
  logic signed [COUNT_BITS-1:0] count_one = '0;
  logic signed [COUNT_BITS-1:0] count_two = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [DUTY_BITS-1:0]         duty_one;
  logic [DUTY_BITS-1:0]         duty_two;
  logic [DUTY_BITS-1:0]         duty_three;
  int                           mismatches;
  int                           outstanding;

  logic signed [COUNT_BITS-1:0] walk_one = '0;
  logic signed [COUNT_BITS-1:0] walk_two = '0;
  bit                           quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  three_channel_led_fader_core #(.COUNT_BITS(COUNT_BITS)) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .toggle_one   (toggle_one),
    .toggle_two   (toggle_two),
    .toggle_three (toggle_three),
    .master_press (master_press),
    .count_one    (count_one),
    .count_two    (count_two),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .duty_one     (duty_one),
    .duty_two     (duty_two),
    .duty_three   (duty_three)
  );

  three_channel_led_fader_core_checker #(.COUNT_BITS(COUNT_BITS)) duty_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .toggle_one   (toggle_one),
    .toggle_two   (toggle_two),
    .toggle_three (toggle_three),
    .master_press (master_press),
    .count_one    (count_one),
    .count_two    (count_two),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .duty_one     (duty_one),
    .duty_two     (duty_two),
    .duty_three   (duty_three),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 37);
  end

  task automatic send_tick(
    input logic [CHANNELS-1:0]          press,
    input logic                         master,
    input logic signed [COUNT_BITS-1:0] pos_one,
    input logic signed [COUNT_BITS-1:0] pos_two
  );
    while (!quiet && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    toggle_one <= press[0];
    toggle_two <= press[1];
    toggle_three <= press[2];
    master_press <= master;
    count_one <= pos_one;
    count_two <= pos_two;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic load_registers(input level_t p1, input level_t p2, input level_t p3,
                                input level_t top, input level_t bottom);
    cfg_we <= 1'b1;
    cfg_index <= CFG_PRESET_ONE;
    cfg_data <= p1;
    @(posedge clk);
    cfg_index <= CFG_PRESET_TWO;
    cfg_data <= p2;
    @(posedge clk);
    cfg_index <= CFG_PRESET_THREE;
    cfg_data <= p3;
    @(posedge clk);
    cfg_index <= CFG_MAX_LEVEL;
    cfg_data <= top;
    @(posedge clk);
    cfg_index <= CFG_MIN_LEVEL;
    cfg_data <= bottom;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly small encoder moves, sometimes a jump anywhere or no move
  function automatic logic signed [COUNT_BITS-1:0] next_walk(
    input logic signed [COUNT_BITS-1:0] pos
  );
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return COUNT_BITS'($urandom);
    if (pick < 25) return pos;
    return pos + COUNT_BITS'($urandom_range(6)) - COUNT_BITS'(3);
  endfunction

  initial begin
    int toggle_pct;
    int master_pct;
    logic [CHANNELS-1:0] press;
    level_t low_bound;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_tick(3'b000, 1'b0, 16'sh7FFF, 16'sh7FFF);
    send_tick(3'b000, 1'b0, 16'sh8000, 16'sh8000);
    send_tick(3'b000, 1'b0, 16'sh8000, 16'sh8000);
    send_tick(3'b000, 1'b0, 16'sh7FFF, 16'sh8000);
    send_tick(3'b001, 1'b0, 16'sh0000, 16'sh0000);
    send_tick(3'b110, 1'b0, 16'sh0001, 16'shFFFF);
    repeat (3) send_tick(3'b000, 1'b0, 16'sh5555, 16'shAAAA);
    send_tick(3'b001, 1'b0, 16'shAAAA, 16'sh5555);
    repeat (2) send_tick(3'b000, 1'b0, 16'shAAAA, 16'sh5555);
    send_tick(3'b000, 1'b1, 16'sh0000, 16'sh0000);
    send_tick(3'b000, 1'b1, 16'sh0000, 16'sh0000);
    repeat (2) send_tick(3'b000, 1'b0, 16'sh0000, 16'sh0000);
    send_tick(3'b111, 1'b1, 16'sh0000, 16'sh0000);
    send_tick(3'b111, 1'b0, 16'sh0000, 16'sh0000);
    send_tick(3'b010, 1'b1, 16'sh7FFF, 16'sh7FFF);
    send_tick(3'b000, 1'b1, 16'sh8000, 16'sh8000);
    send_tick(3'b000, 1'b0, 16'sh8001, 16'sh7FFE);

    for (int phase = 0; phase < 5; phase++) begin
      settle();
      case (phase)
        0: load_registers(8'd255, 8'd0, 8'd128, 8'd255, 8'd0);
        1: load_registers(8'd0, 8'd255, 8'd7, 8'd10, 8'd200);
        2: begin
          low_bound = level_t'($urandom_range(0, 127));
          load_registers(level_t'($urandom), level_t'($urandom), level_t'($urandom),
                         level_t'($urandom_range(128, 255)), low_bound);
        end
        3: load_registers(8'd255, 8'd255, 8'd255, 8'd255, 8'd254);
        default: load_registers(PRESET_ONE_RST, PRESET_TWO_RST, PRESET_THREE_RST,
                                MAX_LEVEL_RST, MIN_LEVEL_RST);
      endcase
      toggle_pct = $urandom_range(1, 5);
      master_pct = $urandom_range(1, 3);
      for (int n = 0; n < PHASE_TICKS; n++) begin
        quiet = (phase == 2) && (n >= 30) && (n < 140);
        for (int ch = 0; ch < CHANNELS; ch++) press[ch] = ($urandom_range(99) < toggle_pct);
        walk_one = next_walk(walk_one);
        walk_two = next_walk(walk_two);
        send_tick(press, $urandom_range(99) < master_pct, walk_one, walk_two);
      end
      quiet = 1'b0;
    end

    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("three_channel_led_fader_core test passed");
    end else begin
      $display("three_channel_led_fader_core test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("three_channel_led_fader_core test failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tclf_pkg.sv
rtl/three_channel_led_fader_core.sv
rtl/tclf_checker.sv
bench/three_channel_led_fader_core_checker.sv
bench/three_channel_led_fader_core_tb.sv
